>>> src/fpr_pkg.sv
// fpr_pkg: shared types and constants for the framed packet receiver.
// No dependencies; imported by every module under src.
package fpr_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN = 11;
    localparam int unsigned CNT_W     = 4;
    localparam logic [CNT_W-1:0] POS_IDLE      = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_SUM_LAST  = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_DATA_LAST = CNT_W'(8);
    localparam logic [CNT_W-1:0] POS_CS        = CNT_W'(9);
    localparam logic [CNT_W-1:0] POS_LAST      = CNT_W'(FRAME_LEN - 1);

    // configuration registers
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'b1;
    localparam logic [7:0] START_BYTE_RST = 8'h02;
    localparam logic [7:0] END_BYTE_RST   = 8'h03;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_END = 2'd1,
        ST_BAD_CS  = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] command;
        logic [31:0] payload;
        logic [15:0] debug_word;
        t_status     status;
    } t_result;

endpackage

>>> src/fpr_collect.sv
// fpr_collect: frame position counter, byte assembly and running checksum.
// Depends on fpr_pkg.
module fpr_collect import fpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_start_byte,
    input  logic [7:0]  i_end_byte,
    output logic        o_last,
    output t_result     o_result
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [63:0]      r_data,  n_data;   // frame bytes 1..8
    logic [7:0]       r_sum,   n_sum;
    logic             r_cs_ok, n_cs_ok;

    always_comb begin
        n_count = r_count;
        n_data  = r_data;
        n_sum   = r_sum;
        n_cs_ok = r_cs_ok;
        if (i_step) begin
            if (r_count == POS_IDLE) begin
                if (i_byte == i_start_byte) begin
                    n_count = CNT_W'(1);
                    n_sum   = 8'd0;
                end
            end else begin
                n_count = (r_count == POS_LAST) ? POS_IDLE : r_count + CNT_W'(1);
                if (r_count <= POS_DATA_LAST) begin
                    n_data = {r_data[55:0], i_byte};
                end
                if (r_count <= POS_SUM_LAST) begin
                    n_sum = r_sum + i_byte;
                end
                if (r_count == POS_CS) begin
                    n_cs_ok = (i_byte == r_sum);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= POS_IDLE;
        end else begin
            r_count <= n_count;
        end
        r_data  <= n_data;
        r_sum   <= n_sum;
        r_cs_ok <= n_cs_ok;
    end

    assign o_last = (r_count == POS_LAST);

    // end byte is checked before the checksum
    always_comb begin
        o_result.command    = r_data[63:48];
        o_result.payload    = r_data[47:16];
        o_result.debug_word = r_data[15:0];
        if (i_byte != i_end_byte) begin
            o_result.status = ST_BAD_END;
        end else if (!r_cs_ok) begin
            o_result.status = ST_BAD_CS;
        end else begin
            o_result.status = ST_GOOD;
        end
    end

endmodule

>>> src/fpr_out_stage.sv
// fpr_out_stage: result register with valid/ready toward the consumer.
// Depends on fpr_pkg.
module fpr_out_stage import fpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> src/framed_packet_receiver.sv
// framed_packet_receiver: top level of the byte-serial frame receiver.
// Depends on fpr_pkg, fpr_collect and fpr_out_stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  rx in    | i_rx_valid / o_rx_ready    | i_rx_byte
//  result   | o_res_valid / i_res_ready  | o_command o_payload o_debug_word
//           |                            | o_status
//  config   | i_cfg_we (no wait)         | i_cfg_idx i_cfg_data
//
// One byte is taken per clock unless a stalled result holds the input register.
// A byte waits in the input register, then steps the frame logic; the eleventh
// byte of a frame loads the result register, which then offers the result.
// Synchronous active-low reset clears valids, the frame position and sets
// start byte 0x02, end byte 0x03. A stalled result only blocks the input
// register when it holds the last byte of the next frame.
module framed_packet_receiver import fpr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received bytes
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    // frame results
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [15:0]          o_command,
    output logic [31:0]          o_payload,
    output logic [15:0]          o_debug_word,
    output logic [1:0]           o_status,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0] r_start_byte, r_end_byte;
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic    w_last, w_out_free, w_adv, w_done;
    t_result w_result, w_res_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_end_byte   <= END_BYTE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_BYTE: r_start_byte <= i_cfg_data;
                REG_END_BYTE:   r_end_byte   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the held byte moves on unless it closes a frame and the result slot is busy
    assign w_adv      = r_in_valid && (!w_last || w_out_free);
    assign w_done     = w_adv && w_last;
    assign o_rx_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    fpr_collect u_collect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_last       (w_last),
        .o_result     (w_result)
    );

    fpr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_done),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_res_valid),
        .i_ready  (i_res_ready),
        .o_result (w_res_out)
    );

    assign o_command    = w_res_out.command;
    assign o_payload    = w_res_out.payload;
    assign o_debug_word = w_res_out.debug_word;
    assign o_status     = w_res_out.status;

    // a finished frame never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_out_free)
        else $error("result register overwritten");

    // a held byte that cannot advance stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a byte");

    // a result only appears after a frame completed
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(w_done))
        else $error("result without a completed frame");

endmodule

>>> tb/sv/fpr_result_checker.sv
`timescale 1ns / 100ps
// fpr_result_checker: watches the byte, result and register ports of the frame
// receiver, predicts every frame result and compares it. Depends on fpr_pkg.
module fpr_result_checker import fpr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    input  logic                 i_rx_ready,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [15:0]          i_command,
    input  logic [31:0]          i_payload,
    input  logic [15:0]          i_debug_word,
    input  logic [1:0]           i_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output logic                 o_in_frame
);

    logic [7:0]       start_val   = START_BYTE_RST;
    logic [7:0]       end_val     = END_BYTE_RST;
    logic             in_frame    = 1'b0;
    logic [CNT_W-1:0] frame_pos   = POS_IDLE;
    logic [7:0]       frame_bytes [FRAME_LEN];
    t_result          expected_frames [$];
    int               fail_count  = 0;
    int               pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_in_frame   = in_frame;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Steps the frame state by one accepted byte; the last byte of a frame
    // queues the result it should produce.
    task automatic take_byte(input logic [7:0] b);
        logic [7:0] sum;
        t_result    res;
        int         k;
        if (!in_frame) begin
            if (b == start_val) begin
                frame_bytes[0] = b;
                frame_pos      = CNT_W'(1);
                in_frame       = 1'b1;
            end
            return;
        end
        frame_bytes[frame_pos] = b;
        frame_pos = frame_pos + 1'b1;
        if (frame_pos < FRAME_LEN)
            return;
        in_frame  = 1'b0;
        frame_pos = POS_IDLE;
        sum = '0;
        for (k = 1; k <= POS_SUM_LAST; k++)
            sum += frame_bytes[k];
        res.command    = {frame_bytes[1], frame_bytes[2]};
        res.payload    = {frame_bytes[3], frame_bytes[4], frame_bytes[5], frame_bytes[6]};
        res.debug_word = {frame_bytes[7], frame_bytes[POS_DATA_LAST]};
        // end byte is judged before the checksum
        if (frame_bytes[POS_LAST] != end_val)
            res.status = ST_BAD_END;
        else if (frame_bytes[POS_CS] != sum)
            res.status = ST_BAD_CS;
        else
            res.status = ST_GOOD;
        expected_frames.push_back(res);
    endtask

    task automatic check_result();
        t_result want;
        if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("result with none expected, command %h", i_command));
            return;
        end
        want = expected_frames.pop_front();
        if (i_command !== want.command)
            report_mismatch($sformatf("command exp %h got %h", want.command, i_command));
        if (i_payload !== want.payload)
            report_mismatch($sformatf("payload exp %h got %h", want.payload, i_payload));
        if (i_debug_word !== want.debug_word)
            report_mismatch($sformatf("debug_word exp %h got %h",
                                      want.debug_word, i_debug_word));
        if (i_status !== want.status)
            report_mismatch($sformatf("status exp %0d got %0d", want.status, i_status));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_val = START_BYTE_RST;
            end_val   = END_BYTE_RST;
            in_frame  = 1'b0;
            frame_pos = POS_IDLE;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_BYTE: start_val = i_cfg_data;
                    REG_END_BYTE:   end_val   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx_valid && i_rx_ready)
                take_byte(i_rx_byte);
            if (i_res_valid && i_res_ready)
                check_result();
        end
        pending_cnt = expected_frames.size();
    end

endmodule

>>> tb/sv/tb_framed_packet_receiver.sv
`timescale 1ns / 100ps
// tb_framed_packet_receiver: stimulus and verdict for the frame receiver.
// Depends on fpr_pkg, framed_packet_receiver and fpr_result_checker.
module tb_framed_packet_receiver;
    import fpr_pkg::*;

    // how the trailer of a generated frame is made
    typedef enum int {
        FR_GOOD,
        FR_BAD_END,
        FR_BAD_SUM,
        FR_BAD_BOTH
    } t_frame_kind;

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } t_rx_mode;

    localparam int PHASE_BYTES = 120;
    localparam int HOLD_CYCLES = 400;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 rx_valid  = 1'b0;
    logic                 rx_ready;
    logic [7:0]           rx_byte   = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [15:0]          command;
    logic [31:0]          payload;
    logic [15:0]          debug_word;
    logic [1:0]           status;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = REG_START_BYTE;
    logic [7:0]           cfg_data  = '0;

    int                   fail_count;
    int                   pending;
    logic                 in_frame;

    // register values the stimulus builds frames with
    logic [7:0]           cur_start  = START_BYTE_RST;
    logic [7:0]           cur_end    = END_BYTE_RST;
    int                   burst_left = 0;

    // long receiver hold-off, asked for by the stimulus, counted by the receiver
    logic                 hold_req   = 1'b0;
    logic                 hold_done  = 1'b0;

    always #2 clk = ~clk;

    framed_packet_receiver u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (rx_valid),
        .o_rx_ready   (rx_ready),
        .i_rx_byte    (rx_byte),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_command    (command),
        .o_payload    (payload),
        .o_debug_word (debug_word),
        .o_status     (status),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    fpr_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (rx_valid),
        .i_rx_ready   (rx_ready),
        .i_rx_byte    (rx_byte),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_command    (command),
        .i_payload    (payload),
        .i_debug_word (debug_word),
        .i_status     (status),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_in_frame   (in_frame)
    );

    // Offers one byte and returns at the edge that takes it. Between bursts
    // valid drops for a random gap; no gaps while the receiver hold-off runs,
    // so the block backs up and pulls rx ready low.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!(hold_req && !hold_done)) begin
                gap = $urandom_range(1, 12);
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        burst_left--;
    endtask

    // Start byte, eight body bytes (command, payload, debug word), checksum
    // over bytes 1..7, end byte. The kind spoils the checksum and/or end byte.
    task automatic send_frame(input t_frame_kind kind, input logic [63:0] body);
        logic [7:0] sum;
        logic [7:0] cs_byte;
        logic [7:0] tail;
        int         k;
        sum = '0;
        send_byte(cur_start);
        for (k = 0; k < 8; k++) begin
            send_byte(body[63 - 8*k -: 8]);
            if (k < 7)
                sum += body[63 - 8*k -: 8];
        end
        cs_byte = sum;
        tail    = cur_end;
        if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH)
            cs_byte = sum ^ 8'($urandom_range(1, 255));
        if (kind == FR_BAD_END || kind == FR_BAD_BOTH)
            tail = cur_end ^ 8'($urandom_range(1, 255));
        send_byte(cs_byte);
        send_byte(tail);
    endtask

    // Pads out any open frame, then waits for every result and for the
    // pipeline to empty, so registers can be written safely.
    task automatic settle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (in_frame) begin
            send_byte(8'($urandom_range(0, 255)));
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    // Both registers, back to back; called only with the block idle.
    task automatic write_regs(input logic [7:0] start_val, input logic [7:0] end_val);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_START_BYTE;
        cfg_data <= start_val;
        @(posedge clk);
        cfg_idx  <= REG_END_BYTE;
        cfg_data <= end_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_start  = start_val;
        cur_end    = end_val;
    endtask

    // Mostly well-formed frames with random content and a random trailer
    // fault; the rest is line noise and frames cut short, which the next
    // bytes then complete out of step. Only bytes that go into a frame
    // count toward the budget.
    task automatic run_phase(input int budget);
        int          taken;
        int          pick;
        int          pos;
        int          cut;
        logic [63:0] body;
        t_frame_kind kind;
        taken = 0;
        while (taken < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                body = {$urandom, $urandom};
                // start byte inside a frame must be taken as data
                if ($urandom_range(0, 3) == 0) begin
                    pos = $urandom_range(0, 7);
                    body[8*pos +: 8] = cur_start;
                end
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    kind = FR_GOOD;
                else if (pick < 7)
                    kind = FR_BAD_END;
                else if (pick < 9)
                    kind = FR_BAD_SUM;
                else
                    kind = FR_BAD_BOTH;
                send_frame(kind, body);
                taken += FRAME_LEN;
            end else if (pick < 88) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                cut = $urandom_range(1, FRAME_LEN - 2);
                send_byte(cur_start);
                repeat (cut) send_byte(8'($urandom_range(0, 255)));
                taken += cut + 1;
            end
        end
        settle();
    endtask

    // Result side: ready follows a randomly chosen stall pattern; a requested
    // hold-off keeps ready low for a long fixed stretch, once.
    initial begin : receiver
        int       cyc;
        int       hold_cnt;
        t_rx_mode mode;
        cyc      = 0;
        hold_cnt = 0;
        mode     = RX_FREE;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = t_rx_mode'($urandom_range(0, 3));
            if (hold_cnt > 0) begin
                hold_cnt--;
                res_ready <= 1'b0;
                if (hold_cnt == 0)
                    hold_done = 1'b1;
            end else if (hold_req && !hold_done) begin
                hold_cnt   = HOLD_CYCLES;
                res_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_FREE:     res_ready <= 1'b1;
                    RX_COIN:     res_ready <= 1'($urandom_range(0, 1));
                    RX_SLOW:     res_ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: res_ready <= (cyc % 7 != 0);
                    default:     res_ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values: idle bytes that are not the start
        // byte, all-ones and all-zero fields, a start byte among the data,
        // checksum wrapping past 8 bits, and each trailer fault.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_BYTE_RST);
        send_frame(FR_GOOD, {16'hFFFF, 32'h0000_0000, START_BYTE_RST, 8'hFF});
        send_frame(FR_GOOD, {16'h0000, 32'hFFFF_FFFF, 16'h0000});
        send_frame(FR_BAD_END, {$urandom, $urandom});
        send_frame(FR_BAD_SUM, {$urandom, $urandom});
        send_frame(FR_BAD_BOTH, {$urandom, $urandom});
        settle();

        // Random phases across register settings, extremes first.
        write_regs(8'h00, 8'hFF);
        run_phase(PHASE_BYTES);
        write_regs(8'hFF, 8'h00);
        hold_req = 1'b1;
        run_phase(PHASE_BYTES);
        write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_phase(PHASE_BYTES);
        // start and end byte equal
        write_regs(8'h7E, 8'h7E);
        run_phase(PHASE_BYTES);
        write_regs(START_BYTE_RST, END_BYTE_RST);
        run_phase(PHASE_BYTES);

        rx_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
src/fpr_pkg.sv
src/fpr_collect.sv
src/fpr_out_stage.sv
src/framed_packet_receiver.sv
tb/sv/fpr_result_checker.sv
tb/sv/tb_framed_packet_receiver.sv
